### rtl/three_phase_sine_pwm_generator_core_assert.svh
// Assertion macros for the three-phase sine PWM generator checker.
`ifndef THREE_PHASE_SINE_PWM_GENERATOR_CORE_ASSERT_SVH
`define THREE_PHASE_SINE_PWM_GENERATOR_CORE_ASSERT_SVH

// Clocked check, masked while reset is held.
`define SPWM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spwm check failed");

// Clocked check that also runs through reset.
`define SPWM_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("spwm reset check failed");

`endif

### rtl/spwm_pkg.sv
// Shared constants, codes and types of the three-phase sine PWM generator.
`timescale 1ns / 1ps
package spwm_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int COUNT_WIDTH = 16;
    localparam int DEAD_WIDTH  = 10;
    localparam int NPHASE      = 3;

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 9;
    localparam int SEL_W      = 2;
    localparam int SAMPLE_W   = 9;
    localparam int LIMIT_W    = 16;
    localparam int STEPS_W    = 10;
    localparam int DTICKS_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int STEP_CMP_W = (IDX_W + 1 > STEPS_W) ? IDX_W + 1 : STEPS_W;
    localparam logic [IDX_W:0] DEPTH_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);

    localparam logic [LIMIT_W-1:0]  RST_PRESCALE_LIMIT = 16'd300;
    localparam logic [LIMIT_W-1:0]  RST_PWM_PERIOD     = 16'd57;
    localparam logic [STEPS_W-1:0]  RST_STEPS_IN_USE   = 10'd120;
    localparam logic [DTICKS_W-1:0] RST_DEAD_TICKS     = 10'd992;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE_LIMIT = 3'd0,
        CFG_PWM_PERIOD     = 3'd1,
        CFG_STEPS_IN_USE   = 3'd2,
        CFG_DEAD_TICKS     = 3'd3,
        CFG_RUN_ENABLE     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        logic [LIMIT_W-1:0]  prescale_limit;
        logic [LIMIT_W-1:0]  pwm_period;
        logic [STEPS_W-1:0]  steps_in_use;
        logic [DTICKS_W-1:0] dead_ticks;
        logic                run_enable;
    } t_cfg;

    // Item as it leaves the timebase stage.
    typedef struct packed {
        logic                   valid;
        logic                   is_tick;
        logic                   ended;
        logic [COUNT_WIDTH-1:0] pwm_count;
        logic [IDX_W-1:0]       step;
    } t_stage;

    typedef struct packed {
        logic [NPHASE-1:0]  we;
        logic [IDX_W-1:0]   addr;
        logic [VALUE_W-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic                valid;
        logic [NPHASE-1:0]   high;
        logic [NPHASE-1:0]   low;
        logic [SAMPLE_W-1:0] sample_index;
        logic                period_end;
    } t_result;

endpackage

### rtl/spwm_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface spwm_item_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [spwm_pkg::SEL_W-1:0]       phase_sel;
    logic [spwm_pkg::INDEX_W-1:0]     entry_index;
    logic [spwm_pkg::VALUE_W-1:0]     entry_value;

    modport source (output valid, output op, output phase_sel, output entry_index,
                    output entry_value, input ready);
    modport sink (input valid, input op, input phase_sel, input entry_index,
                  input entry_value, output ready);
endinterface

interface spwm_result_if;
    logic                          valid;
    logic                          ready;
    logic                          a_high;
    logic                          a_low;
    logic                          b_high;
    logic                          b_low;
    logic                          c_high;
    logic                          c_low;
    logic [spwm_pkg::SAMPLE_W-1:0] sample_index;
    logic                          period_end;

    modport source (output valid, output a_high, output a_low, output b_high,
                    output b_low, output c_high, output c_low, output sample_index,
                    output period_end, input ready);
    modport sink (input valid, input a_high, input a_low, input b_high,
                  input b_low, input c_high, input c_low, input sample_index,
                  input period_end, output ready);
endinterface

interface spwm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [spwm_pkg::CFG_IDX_W-1:0]  index;
    logic [spwm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/spwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/spwm_timebase.sv
// Prescaler, PWM counter and table index stage; also steers table loads.
`timescale 1ns / 1ps
module spwm_timebase (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic                           i_op,
    input  logic [spwm_pkg::SEL_W-1:0]     i_sel,
    input  logic [spwm_pkg::INDEX_W-1:0]   i_idx,
    input  logic [spwm_pkg::VALUE_W-1:0]   i_val,
    input  spwm_pkg::t_cfg                 i_cfg,
    output logic [spwm_pkg::IDX_W-1:0]     o_raddr,
    output spwm_pkg::t_tbl_wr              o_wr,
    output spwm_pkg::t_stage               o_stage
);

    logic                                r_valid;
    logic [spwm_pkg::COUNT_WIDTH-1:0]    r_presc;
    logic [spwm_pkg::COUNT_WIDTH-1:0]    r_pwm;
    logic [spwm_pkg::IDX_W-1:0]          r_step;
    logic                                r_is_tick;
    logic                                r_ended;

    logic [spwm_pkg::COUNT_WIDTH-1:0]    n_presc;
    logic [spwm_pkg::COUNT_WIDTH-1:0]    n_pwm;
    logic [spwm_pkg::IDX_W-1:0]          n_step;
    logic                                n_ended;

    logic                                w_accept;
    logic                                w_tick;
    logic                                w_idx_ok;
    logic [spwm_pkg::IDX_W:0]            w_inc;
    logic [spwm_pkg::IDX_W-1:0]          w_step_next;

    assign w_accept = i_valid & i_adv;
    assign w_tick   = w_accept && (i_op == spwm_pkg::OP_TICK);
    assign w_idx_ok = 32'(i_idx) < spwm_pkg::TABLE_DEPTH;

    // Wrap the shared index at the steps in use or at the table end.
    always_comb begin
        w_inc = {1'b0, r_step} + 1'b1;
        if ((spwm_pkg::STEP_CMP_W'(w_inc) >= spwm_pkg::STEP_CMP_W'(i_cfg.steps_in_use)) ||
            (w_inc >= spwm_pkg::DEPTH_LIMIT)) begin
            w_step_next = '0;
        end else begin
            w_step_next = w_inc[spwm_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        n_presc = r_presc;
        n_pwm   = r_pwm;
        n_step  = r_step;
        n_ended = 1'b0;
        if (w_tick) begin
            if (!i_cfg.run_enable) begin
                n_presc = '0;
                n_pwm   = '0;
                n_step  = '0;
            end else if (r_presc >= spwm_pkg::COUNT_WIDTH'(i_cfg.prescale_limit)) begin
                n_presc = '0;
                if (r_pwm >= spwm_pkg::COUNT_WIDTH'(i_cfg.pwm_period)) begin
                    n_pwm   = '0;
                    n_ended = 1'b1;
                    n_step  = w_step_next;
                end else begin
                    n_pwm = r_pwm + 1'b1;
                end
            end else begin
                n_presc = r_presc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_presc <= '0;
            r_pwm   <= '0;
            r_step  <= '0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            r_presc <= n_presc;
            r_pwm   <= n_pwm;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_is_tick <= (i_op == spwm_pkg::OP_TICK);
            r_ended   <= n_ended;
        end
    end

    // Tables are read at the index in force before this item's update.
    assign o_raddr = r_step;

    always_comb begin
        for (int p = 0; p < spwm_pkg::NPHASE; p++) begin
            o_wr.we[p] = w_accept && (i_op == spwm_pkg::OP_LOAD) &&
                         (i_sel == spwm_pkg::SEL_W'(p)) && w_idx_ok;
        end
        o_wr.addr = spwm_pkg::IDX_W'(i_idx);
        o_wr.data = i_val;
    end

    assign o_stage.valid     = r_valid;
    assign o_stage.is_tick   = r_is_tick;
    assign o_stage.ended     = r_ended;
    assign o_stage.pwm_count = r_pwm;
    assign o_stage.step      = r_step;

endmodule

### rtl/spwm_phase.sv
// Per-phase compare, reference edge detect, dead-time counters and result register.
`timescale 1ns / 1ps
module spwm_phase (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_adv,
    input  spwm_pkg::t_stage                                   i_stage,
    input  logic [spwm_pkg::NPHASE-1:0][spwm_pkg::VALUE_W-1:0] i_rdata,
    input  spwm_pkg::t_cfg                                     i_cfg,
    output spwm_pkg::t_result                                  o_res
);

    logic [spwm_pkg::NPHASE-1:0][spwm_pkg::COUNT_WIDTH-1:0] r_cmp;
    logic [spwm_pkg::NPHASE-1:0][spwm_pkg::DEAD_WIDTH-1:0]  r_dead;
    logic [spwm_pkg::NPHASE-1:0]                            r_prev;
    spwm_pkg::t_result                                      r_res;

    logic [spwm_pkg::NPHASE-1:0][spwm_pkg::COUNT_WIDTH-1:0] n_cmp;
    logic [spwm_pkg::NPHASE-1:0][spwm_pkg::DEAD_WIDTH-1:0]  n_dead;
    logic [spwm_pkg::NPHASE-1:0]                            n_prev;
    spwm_pkg::t_result                                      n_res;

    logic w_run_tick;
    logic w_stop_tick;
    logic w_ref;

    assign w_run_tick  = i_stage.valid && i_stage.is_tick && i_cfg.run_enable;
    assign w_stop_tick = i_stage.valid && i_stage.is_tick && !i_cfg.run_enable;

    always_comb begin
        n_cmp  = r_cmp;
        n_dead = r_dead;
        n_prev = r_prev;
        w_ref  = 1'b0;
        for (int p = 0; p < spwm_pkg::NPHASE; p++) begin
            if (w_run_tick && i_stage.ended) begin
                n_cmp[p] = spwm_pkg::COUNT_WIDTH'(i_rdata[p]);
            end
            w_ref = i_stage.pwm_count < n_cmp[p];
            if (w_stop_tick) begin
                n_dead[p] = '0;
                n_prev[p] = 1'b0;
            end else if (w_run_tick) begin
                if (w_ref != r_prev[p]) begin
                    n_dead[p] = spwm_pkg::DEAD_WIDTH'(i_cfg.dead_ticks);
                    n_prev[p] = w_ref;
                end else if (r_dead[p] != '0) begin
                    n_dead[p] = r_dead[p] - 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_res.valid        = i_stage.valid;
        n_res.sample_index = spwm_pkg::SAMPLE_W'(i_stage.step);
        n_res.period_end   = i_stage.ended;
        for (int p = 0; p < spwm_pkg::NPHASE; p++) begin
            if (!i_cfg.run_enable) begin
                n_res.high[p] = 1'b0;
                n_res.low[p]  = 1'b1;
            end else begin
                n_res.high[p] = n_prev[p] && (n_dead[p] == '0);
                n_res.low[p]  = !n_prev[p] && (n_dead[p] == '0);
            end
        end
    end

    // Reset clears only the valid flag of the result; its payload holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp       <= '0;
            r_dead      <= '0;
            r_prev      <= '0;
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r_cmp  <= n_cmp;
            r_dead <= n_dead;
            r_prev <= n_prev;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/three_phase_sine_pwm_generator_core.sv
// Top level of the three-phase sine PWM generator with dead time.
`timescale 1ns / 1ps
// The block takes one item per clock: a tick, which advances the prescaler,
// the PWM up-counter and at each period end the shared table index, or a load,
// which writes one compare value into the sine table of phase A, B or C. Every
// item gives exactly one result, which carries the six gate drives after the
// item, the table index that the next period end will read and a period-end flag.
// Each item is registered first in the timebase stage and then in the result
// register, from which its result is offered and taken; the block sustains
// one item per cycle as long as results are taken; a stalled result holds the
// pipe, and input ready then drops. The two stages are set by the registered
// read of the sine tables: each phase has its own 512-entry table RAM, read at
// the current index at the edge a tick is transferred, and the compare,
// reference and dead-time logic uses the data one stage later. A load
// writes its RAM at the transfer edge, so a tick right behind it sees the new
// entry. Table entries power up unknown and must be loaded before the first
// period end that reads them; there is no clearing pass after reset. With
// run_enable low every high drive is 0 and every low drive is 1. Configuration
// writes are always ready and belong in idle time only.
module three_phase_sine_pwm_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spwm_item_if.sink   i_in,
    spwm_result_if.source o_out,
    spwm_cfg_if.sink    i_cfg
);

    spwm_pkg::t_cfg                                      r_cfg;
    spwm_pkg::t_cfg                                      n_cfg;

    logic                                                w_adv;
    logic [spwm_pkg::IDX_W-1:0]                          w_raddr;
    spwm_pkg::t_tbl_wr                                   w_wr;
    spwm_pkg::t_stage                                    w_stage;
    logic [spwm_pkg::NPHASE-1:0][spwm_pkg::VALUE_W-1:0]  w_rdata;
    spwm_pkg::t_result                                   w_res;

    // Register file: decode the index, drop writes past the last register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                spwm_pkg::CFG_PRESCALE_LIMIT: begin
                    n_cfg.prescale_limit = spwm_pkg::LIMIT_W'(i_cfg.data);
                end
                spwm_pkg::CFG_PWM_PERIOD: begin
                    n_cfg.pwm_period = spwm_pkg::LIMIT_W'(i_cfg.data);
                end
                spwm_pkg::CFG_STEPS_IN_USE: begin
                    n_cfg.steps_in_use = spwm_pkg::STEPS_W'(i_cfg.data);
                end
                spwm_pkg::CFG_DEAD_TICKS: begin
                    n_cfg.dead_ticks = spwm_pkg::DTICKS_W'(i_cfg.data);
                end
                spwm_pkg::CFG_RUN_ENABLE: begin
                    n_cfg.run_enable = i_cfg.data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_limit <= spwm_pkg::RST_PRESCALE_LIMIT;
            r_cfg.pwm_period     <= spwm_pkg::RST_PWM_PERIOD;
            r_cfg.steps_in_use   <= spwm_pkg::RST_STEPS_IN_USE;
            r_cfg.dead_ticks     <= spwm_pkg::RST_DEAD_TICKS;
            r_cfg.run_enable     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign i_cfg.ready = 1'b1;

    // The whole pipe moves together whenever the result register is free
    // or its result is being taken in this cycle.
    assign w_adv      = !w_res.valid || o_out.ready;
    assign i_in.ready = w_adv;

    spwm_timebase u_timebase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_sel   (i_in.phase_sel),
        .i_idx   (i_in.entry_index),
        .i_val   (i_in.entry_value),
        .i_cfg   (r_cfg),
        .o_raddr (w_raddr),
        .o_wr    (w_wr),
        .o_stage (w_stage)
    );

    // One table bank per phase so all three compare values are read at once.
    for (genvar p = 0; p < spwm_pkg::NPHASE; p++) begin : g_bank
        spwm_ram #(
            .WIDTH (spwm_pkg::VALUE_W),
            .DEPTH (spwm_pkg::TABLE_DEPTH)
        ) u_table (
            .i_clk   (i_clk),
            .i_we    (w_wr.we[p]),
            .i_waddr (w_wr.addr),
            .i_wdata (w_wr.data),
            .i_re    (w_adv),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[p])
        );
    end

    spwm_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_stage (w_stage),
        .i_rdata (w_rdata),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Phase A is bit 0, B bit 1, C bit 2 of the drive vectors.
    assign o_out.valid        = w_res.valid;
    assign o_out.a_high       = w_res.high[0];
    assign o_out.a_low        = w_res.low[0];
    assign o_out.b_high       = w_res.high[1];
    assign o_out.b_low        = w_res.low[1];
    assign o_out.c_high       = w_res.high[2];
    assign o_out.c_low        = w_res.low[2];
    assign o_out.sample_index = w_res.sample_index;
    assign o_out.period_end   = w_res.period_end;

endmodule

### rtl/spwm_checker.sv
// Port-level assertions for the three-phase sine PWM generator, bound to the top level.
`timescale 1ns / 1ps
`include "three_phase_sine_pwm_generator_core_assert.svh"
module spwm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_a_high,
    input logic                          i_a_low,
    input logic                          i_b_high,
    input logic                          i_b_low,
    input logic                          i_c_high,
    input logic                          i_c_low,
    input logic [spwm_pkg::SAMPLE_W-1:0] i_sample_index,
    input logic                          i_period_end
);

    // Reset empties the result register.
    `SPWM_ASSERT_NORST(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // Input is never held off while no result is waiting.
    `SPWM_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

    // No phase ever drives both switches on.
    `SPWM_ASSERT(a_no_shoot_through, i_clk, i_rst_n, i_out_valid |-> !(i_a_high && i_a_low) && !(i_b_high && i_b_low) && !(i_c_high && i_c_low))

    // A stalled result stays put.
    `SPWM_ASSERT(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_a_high) && $stable(i_a_low) && $stable(i_b_high) && $stable(i_b_low) && $stable(i_c_high) && $stable(i_c_low) && $stable(i_sample_index) && $stable(i_period_end))

endmodule

bind three_phase_sine_pwm_generator_core spwm_checker u_spwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_a_high       (o_out.a_high),
    .i_a_low        (o_out.a_low),
    .i_b_high       (o_out.b_high),
    .i_b_low        (o_out.b_low),
    .i_c_high       (o_out.c_high),
    .i_c_low        (o_out.c_low),
    .i_sample_index (o_out.sample_index),
    .i_period_end   (o_out.period_end)
);
